// ----- sv/lztd_pkg.sv -----
// Shared types and constants for the LZ77 token decompressor.
// No dependencies; imported by lztd_outreg, lztd_core and the top level.
package lztd_pkg;

  localparam int HISTORY_DEPTH_DEF    = 65536;
  localparam int BYTES_PER_RESULT_DEF = 4;
  localparam int OUT_BYTES            = 4;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_CAPACITY = 2'd0;
  localparam logic [1:0] CFG_STD_MODE     = 2'd1;
  localparam logic [1:0] CFG_TURBO_MODE   = 2'd2;

  localparam logic [15:0] MAX_CAPACITY_RST = 16'hFFFF;
  localparam logic [7:0]  STD_MODE_RST     = 8'h00;
  localparam logic [7:0]  TURBO_MODE_RST   = 8'h01;

  // header byte positions
  localparam logic [3:0] HDR_MODE   = 4'd4;
  localparam logic [3:0] HDR_LEN_HI = 4'd6;
  localparam logic [3:0] HDR_LEN_LO = 4'd7;
  localparam logic [3:0] HDR_BYTES  = 4'd8;

  localparam logic [7:0] MAGIC [4] = '{8'h43, 8'h54, 8'h58, 8'h46};

  // status / error codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FORMAT   = 2'd1;
  localparam logic [1:0] ST_CAPACITY = 2'd2;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    PH_TOKEN,
    PH_DIST_HI,
    PH_DIST_LO
  } phase_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COPY,
    S_STATUS
  } state_t;

  typedef struct packed {
    logic                      kind;
    logic [OUT_BYTES-1:0][7:0] bytes;
    logic [2:0]                count;
    logic [1:0]                status;
    logic [15:0]               length;
    logic                      last;
  } result_t;

endpackage

// ----- sv/lztd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing; used for the history store.
module lztd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read during write to the same entry returns the old contents
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/lztd_outreg.sv -----
// Output holding register between the decoder and the result channel.
// Depends on lztd_pkg for the result struct.
module lztd_outreg
  import lztd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t din,
  output logic    free,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t dout
);

  logic    valid;
  result_t data;

  assign free      = !valid || !out_stall;
  assign out_valid = valid;
  assign dout      = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push) begin
      valid <= 1'b1;
    end else if (!out_stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data <= din;
    end
  end

endmodule

// ----- sv/lztd_core.sv -----
// Header parser, token decoder and match copy sequencer of the decompressor.
// Depends on lztd_pkg; drives the history RAM and the output register.
module lztd_core
  import lztd_pkg::*;
#(
  parameter int HISTORY_DEPTH    = HISTORY_DEPTH_DEF,
  parameter int BYTES_PER_RESULT = BYTES_PER_RESULT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [1:0]                       cfg_index,
  input  logic [15:0]                      cfg_data,
  input  logic                             in_valid,
  input  logic [7:0]                       in_byte,
  input  logic                             end_of_block,
  output logic                             in_stall,
  input  logic                             out_free,
  output logic                             push,
  output result_t                          res,
  output logic                             ram_we,
  output logic [$clog2(HISTORY_DEPTH)-1:0] ram_waddr,
  output logic [7:0]                       ram_wdata,
  output logic [$clog2(HISTORY_DEPTH)-1:0] ram_raddr,
  input  logic [7:0]                       ram_rdata
);

  localparam int AW    = $clog2(HISTORY_DEPTH);
  localparam int CHUNK = (BYTES_PER_RESULT < OUT_BYTES) ? BYTES_PER_RESULT : OUT_BYTES;

  // configuration
  logic [15:0] max_capacity;
  logic [7:0]  std_mode, turbo_mode;

  // block state
  state_t      state, state_next;
  logic [3:0]  header_index, header_index_next;
  logic        lz_decoding, lz_decoding_next;
  logic [15:0] original_length, original_length_next;
  logic [15:0] write_position, write_position_next;
  phase_t      token_phase, token_phase_next;
  logic [6:0]  pending_length, pending_length_next;
  logic [7:0]  distance_high, distance_high_next;
  logic [1:0]  error_code, error_code_next;
  logic        finished, finished_next;
  logic        eob_saved, eob_saved_next;

  // copy sequencer
  logic [AW-1:0]             src, src_next;
  logic [6:0]                remaining, remaining_next;
  logic [2:0]                fill, fill_next;
  logic [OUT_BYTES-1:0][7:0] chunk, chunk_next;
  logic [7:0]                last_byte, last_byte_next;
  logic                      fwd_ok, fwd_ok_next;
  logic                      dist_one, dist_one_next;

  logic          accept;
  logic [15:0]   match_dist;
  logic          dist_bad;
  logic [AW-1:0] src_start;
  logic          wp_full, wp_full_after;
  logic          start_copy;
  logic          cap_hit, emit_byte, emit_cap, need_emit, adv, copy_done;
  logic [6:0]    rem_after;
  logic [2:0]    fill_after;
  logic [7:0]    copy_byte;
  logic [16:0]   wp_inc;

  assign in_stall   = !(state == S_IDLE && out_free);
  assign accept     = in_valid && !in_stall;
  assign match_dist = {distance_high, in_byte};
  assign dist_bad   = (match_dist == 16'd0) || (match_dist > write_position);
  assign src_start  = AW'(write_position - match_dist);
  assign wp_full    = write_position >= max_capacity;
  assign wp_inc     = {1'b0, write_position} + 17'd1;
  assign wp_full_after = wp_inc >= {1'b0, max_capacity};

  assign start_copy = accept && error_code == ST_OK && header_index >= HDR_BYTES
                      && lz_decoding && token_phase == PH_DIST_LO && !dist_bad
                      && pending_length != 7'd0;

  // copy step: a distance of one (modulo depth) reads the entry written in the same cycle
  assign copy_byte  = (dist_one && fwd_ok) ? last_byte : ram_rdata;
  assign cap_hit    = wp_full;
  assign rem_after  = remaining - 7'd1;
  assign fill_after = fill + 3'd1;
  assign emit_byte  = !cap_hit && (fill_after == 3'(CHUNK) || rem_after == 7'd0);
  assign emit_cap   = cap_hit && fill != 3'd0;
  assign need_emit  = emit_byte || emit_cap;
  assign adv        = !need_emit || out_free;
  assign copy_done  = adv && (cap_hit || rem_after == 7'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_capacity <= MAX_CAPACITY_RST;
      std_mode     <= STD_MODE_RST;
      turbo_mode   <= TURBO_MODE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MAX_CAPACITY: max_capacity <= cfg_data;
        CFG_STD_MODE:     std_mode     <= cfg_data[7:0];
        CFG_TURBO_MODE:   turbo_mode   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin : p_state_next
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start_copy) begin
          state_next = S_COPY;
        end else if (accept && end_of_block) begin
          state_next = S_STATUS;
        end
      end
      S_COPY: begin
        if (copy_done) begin
          state_next = eob_saved ? S_STATUS : S_IDLE;
        end
      end
      S_STATUS: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin : p_datapath
    header_index_next    = header_index;
    lz_decoding_next     = lz_decoding;
    original_length_next = original_length;
    write_position_next  = write_position;
    token_phase_next     = token_phase;
    pending_length_next  = pending_length;
    distance_high_next   = distance_high;
    error_code_next      = error_code;
    finished_next        = finished;
    eob_saved_next       = eob_saved;
    src_next             = src;
    remaining_next       = remaining;
    fill_next            = fill;
    chunk_next           = chunk;
    last_byte_next       = last_byte;
    fwd_ok_next          = fwd_ok;
    dist_one_next        = dist_one;
    ram_we               = 1'b0;
    ram_waddr            = write_position[AW-1:0];
    ram_wdata            = in_byte;
    ram_raddr            = src;
    push                 = 1'b0;
    res                  = '0;

    case (state)
      S_IDLE: begin
        ram_raddr = src_start;
        if (accept) begin
          if (error_code == ST_OK) begin
            if (header_index < HDR_BYTES) begin
              case (header_index) inside
                [4'd0:4'd3]: begin
                  if (in_byte != MAGIC[header_index[1:0]]) error_code_next = ST_FORMAT;
                end
                HDR_MODE:   lz_decoding_next = (in_byte == std_mode) || (in_byte == turbo_mode);
                HDR_LEN_HI: original_length_next = {in_byte, 8'h00};
                HDR_LEN_LO: original_length_next = {original_length[15:8], in_byte};
                default: ;
              endcase
              header_index_next = header_index + 4'd1;
              if (header_index == HDR_LEN_LO && error_code_next == ST_OK
                  && original_length_next > max_capacity) begin
                error_code_next = ST_CAPACITY;
              end
            end else if (!lz_decoding) begin
              // raw mode: bytes past capacity are dropped without error
              if (!wp_full) begin
                ram_we              = 1'b1;
                write_position_next = wp_inc[15:0];
                push                = 1'b1;
                res.kind            = KIND_DATA;
                res.bytes[0]        = in_byte;
                res.count           = 3'd1;
                res.last            = !end_of_block;
              end
            end else begin
              case (token_phase)
                PH_TOKEN: begin
                  if (finished || write_position >= original_length) begin
                    finished_next = 1'b1;
                  end else if (in_byte[7]) begin
                    pending_length_next = in_byte[6:0];
                    token_phase_next    = PH_DIST_HI;
                  end else if (!wp_full) begin
                    ram_we              = 1'b1;
                    write_position_next = wp_inc[15:0];
                    push                = 1'b1;
                    res.kind            = KIND_DATA;
                    res.bytes[0]        = in_byte;
                    res.count           = 3'd1;
                    res.last            = !end_of_block;
                  end else begin
                    error_code_next = ST_CAPACITY;
                  end
                end
                PH_DIST_HI: begin
                  distance_high_next = in_byte;
                  token_phase_next   = PH_DIST_LO;
                end
                PH_DIST_LO: begin
                  token_phase_next = PH_TOKEN;
                  if (dist_bad) begin
                    error_code_next = ST_FORMAT;
                  end else if (pending_length != 7'd0) begin
                    src_next       = src_start;
                    remaining_next = pending_length;
                    fill_next      = 3'd0;
                    fwd_ok_next    = 1'b0;
                    dist_one_next  = match_dist[AW-1:0] == AW'(1);
                  end
                end
                default: ;
              endcase
            end
          end
          eob_saved_next = end_of_block;
          if (end_of_block && error_code_next == ST_OK
              && (header_index_next < HDR_BYTES || token_phase_next != PH_TOKEN)) begin
            error_code_next = ST_FORMAT;
          end
        end
      end

      S_COPY: begin
        ram_wdata = copy_byte;
        ram_raddr = (adv && !cap_hit) ? src + AW'(1) : src;
        if (adv) begin
          if (cap_hit) begin
            error_code_next = ST_CAPACITY;
          end else begin
            ram_we                  = 1'b1;
            write_position_next     = wp_inc[15:0];
            chunk_next[fill[1:0]]   = copy_byte;
            fill_next               = emit_byte ? 3'd0 : fill_after;
            remaining_next          = rem_after;
            src_next                = src + AW'(1);
            last_byte_next          = copy_byte;
            fwd_ok_next             = 1'b1;
          end
          if (need_emit) begin
            push     = 1'b1;
            res.kind = KIND_DATA;
            for (int i = 0; i < OUT_BYTES; i++) begin
              if (3'(i) < fill) begin
                res.bytes[i] = chunk[i];
              end else if (!cap_hit && 3'(i) == fill) begin
                res.bytes[i] = copy_byte;
              end
            end
            res.count = cap_hit ? fill : fill_after;
            // last if !eob_saved and the copy ends here or next byte would hit capacity
            res.last  = !eob_saved && (cap_hit || rem_after == 7'd0 || wp_full_after);
          end
        end
      end

      S_STATUS: begin
        if (out_free) begin
          push                 = 1'b1;
          res.kind             = KIND_STATUS;
          res.status           = error_code;
          res.length           = write_position;
          res.last             = 1'b1;
          header_index_next    = 4'd0;
          lz_decoding_next     = 1'b0;
          original_length_next = 16'd0;
          write_position_next  = 16'd0;
          token_phase_next     = PH_TOKEN;
          pending_length_next  = 7'd0;
          distance_high_next   = 8'd0;
          error_code_next      = ST_OK;
          finished_next        = 1'b0;
          eob_saved_next       = 1'b0;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      header_index    <= 4'd0;
      lz_decoding     <= 1'b0;
      original_length <= 16'd0;
      write_position  <= 16'd0;
      token_phase     <= PH_TOKEN;
      pending_length  <= 7'd0;
      distance_high   <= 8'd0;
      error_code      <= ST_OK;
      finished        <= 1'b0;
      eob_saved       <= 1'b0;
      remaining       <= 7'd0;
      fill            <= 3'd0;
      fwd_ok          <= 1'b0;
    end else begin
      state           <= state_next;
      header_index    <= header_index_next;
      lz_decoding     <= lz_decoding_next;
      original_length <= original_length_next;
      write_position  <= write_position_next;
      token_phase     <= token_phase_next;
      pending_length  <= pending_length_next;
      distance_high   <= distance_high_next;
      error_code      <= error_code_next;
      finished        <= finished_next;
      eob_saved       <= eob_saved_next;
      remaining       <= remaining_next;
      fill            <= fill_next;
      fwd_ok          <= fwd_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    src       <= src_next;
    chunk     <= chunk_next;
    last_byte <= last_byte_next;
    dist_one  <= dist_one_next;
  end

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free)
    else $error("result pushed while output register is occupied");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    state == S_COPY |-> (fill < 3'(CHUNK) && remaining != 7'd0))
    else $error("copy sequencer out of range");

  a_block_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_STATUS && out_free) |=>
      (header_index == 4'd0 && write_position == 16'd0 && error_code == ST_OK))
    else $error("block state not cleared after status transfer");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (error_code != ST_OK && !(state == S_STATUS && out_free)) |=>
      error_code == $past(error_code))
    else $error("first error code overwritten");

endmodule

// ----- sv/lz77_token_decompressor_top.sv -----
// Top level of the LZ77 token decompressor: core, history RAM, output register.
// Depends on lztd_pkg, lztd_ram, lztd_outreg and lztd_core.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------------
//   input   | in        | in_valid / in_stall   | in_byte, end_of_block
//   result  | out       | out_valid / out_stall | kind, byte0..3, byte_count, status,
//           |           |                      | output_length, last
//   config  | in        | cfg_write            | cfg_index, cfg_data
//
// Header, literal and raw-mode bytes are taken one per cycle while the output register is
// free; it lets the next byte in while its result is taken. After the last distance byte
// a match is copied in S_COPY: the history RAM has one read port, so one byte is copied
// per cycle unless the output register stalls. in_stall is held while copying, while a status
// result waits in S_STATUS, or while the output register is full and stalled.
// Reset is synchronous; the history RAM is not cleared and needs no clearing pass.
// HISTORY_DEPTH must be a power of two.
module lz77_token_decompressor_top
  import lztd_pkg::*;
#(
  parameter int HISTORY_DEPTH    = HISTORY_DEPTH_DEF,
  parameter int BYTES_PER_RESULT = BYTES_PER_RESULT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [7:0]  byte0,
  output logic [7:0]  byte1,
  output logic [7:0]  byte2,
  output logic [7:0]  byte3,
  output logic [2:0]  byte_count,
  output logic [1:0]  status,
  output logic [15:0] output_length,
  output logic        last
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  logic          out_free, push;
  result_t       res, res_q;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  lztd_core #(
    .HISTORY_DEPTH    (HISTORY_DEPTH),
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_byte      (in_byte),
    .end_of_block (end_of_block),
    .in_stall     (in_stall),
    .out_free     (out_free),
    .push         (push),
    .res          (res),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  lztd_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lztd_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dout      (res_q)
  );

  assign kind          = res_q.kind;
  assign byte0         = res_q.bytes[0];
  assign byte1         = res_q.bytes[1];
  assign byte2         = res_q.bytes[2];
  assign byte3         = res_q.bytes[3];
  assign byte_count    = res_q.count;
  assign status        = res_q.status;
  assign output_length = res_q.length;
  assign last          = res_q.last;

endmodule
